// File: hdl/periodic_tick_hook_table_unit_defines.svh
// assertion macros for the periodic tick hook table unit
`ifndef PERIODIC_TICK_HOOK_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_TICK_HOOK_TABLE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// condition implies consequence in the next cycle
`define PTHT_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("periodic tick hook table: next-cycle check failed");
// condition implies consequence in the same cycle
`define PTHT_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("periodic tick hook table: same-cycle check failed");
`else
`define PTHT_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`define PTHT_ASSERT_NOW(label, clk, rst_n, cond, conseq)
`endif
`endif

// File: hdl/ptht_pkg.sv
// shared types and constants of the periodic tick hook table
package ptht_pkg;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 8;
  localparam int PERIOD_W = 32;
  localparam int MASK_W   = 8;
  localparam int INDEX_W  = 3;
  localparam int COUNT_W  = 32;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HOOK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNHOOK = 2'd2;

  // operation strobes from the controller to the datapath
  typedef struct packed {
    logic load;
    logic tick;
    logic hook;
    logic unhook;
  } ctrl_t;

  // table status back to the controller
  typedef struct packed {
    logic table_full;
    logic table_empty;
  } stat_t;

endpackage

// File: hdl/periodic_tick_hook_table_unit.sv
// Periodic tick hook table: SLOTS periodic tick dividers next to a millisecond
// counter that counts ticks. Each transaction is a tick, a hook or an unhook and
// gives one result. All slots compare and update in parallel lanes, and the
// result register accepts a new transaction while the previous result is taken,
// so one transaction per clock is sustained while the result side does not stall.
// Free-slot and id searches are priority picks over the busy and owner lanes.
`include "periodic_tick_hook_table_unit_defines.svh"
module periodic_tick_hook_table_unit #(
  parameter int SLOTS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ptht_pkg::CMD_W-1:0]       in_command,
  input  logic [ptht_pkg::ID_W-1:0]        in_hook_id,
  input  logic [ptht_pkg::PERIOD_W-1:0]    in_period,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ptht_pkg::MASK_W-1:0]      out_fire_mask,
  output logic [ptht_pkg::INDEX_W-1:0]     out_slot_index,
  output logic                             out_accepted,
  output logic [ptht_pkg::COUNT_W-1:0]     out_ms_count
);

  ptht_pkg::ctrl_t ctrl;
  ptht_pkg::stat_t stat;

  ptht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  ptht_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .in_hook_id     (in_hook_id),
    .in_period      (in_period),
    .out_fire_mask  (out_fire_mask),
    .out_slot_index (out_slot_index),
    .out_accepted   (out_accepted),
    .out_ms_count   (out_ms_count)
  );

  `PTHT_ASSERT_NEXT(a_tick_not_accepted, clk, rst_n, ctrl.tick, out_valid && !out_accepted)
  `PTHT_ASSERT_NEXT(a_hook_room_placed, clk, rst_n, ctrl.hook && !stat.table_full, out_accepted)
  `PTHT_ASSERT_NEXT(a_no_fire_off_tick, clk, rst_n, ctrl.load && !ctrl.tick, out_fire_mask == '0)
  `PTHT_ASSERT_NOW(a_ops_exclusive, clk, rst_n, ctrl.tick, !ctrl.hook && !ctrl.unhook)

endmodule

// File: hdl/ptht_ctrl.sv
// controller: handshake, result register occupancy and command decode
module ptht_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ptht_pkg::CMD_W-1:0]    in_command,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  ptht_pkg::stat_t               stat,
  output ptht_pkg::ctrl_t               ctrl
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_r, state_nxt;
  logic exec;

  // the result register is free when empty or being taken this cycle
  assign in_stall  = (state_r == ST_FULL) && out_stall;
  assign exec      = in_valid && !in_stall;
  assign out_valid = (state_r == ST_FULL);

  always_comb begin
    ctrl.load   = exec;
    ctrl.tick   = exec && (in_command == ptht_pkg::CMD_TICK);
    // a hook may free its own old slot first, so a full table still goes ahead
    ctrl.hook   = exec && (in_command == ptht_pkg::CMD_HOOK);
    // an empty table has nothing to release
    ctrl.unhook = exec && (in_command == ptht_pkg::CMD_UNHOOK) && !stat.table_empty;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (exec) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (!exec && !out_stall) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/ptht_datapath.sv
// datapath: slot lanes, millisecond counter and result register
module ptht_datapath #(
  parameter int SLOTS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ptht_pkg::ctrl_t                  ctrl,
  output ptht_pkg::stat_t                  stat,
  input  logic [ptht_pkg::ID_W-1:0]        in_hook_id,
  input  logic [ptht_pkg::PERIOD_W-1:0]    in_period,
  output logic [ptht_pkg::MASK_W-1:0]      out_fire_mask,
  output logic [ptht_pkg::INDEX_W-1:0]     out_slot_index,
  output logic                             out_accepted,
  output logic [ptht_pkg::COUNT_W-1:0]     out_ms_count
);

  localparam int MW = ptht_pkg::MASK_W;

  logic [SLOTS-1:0]                   busy_r, busy_nxt;
  logic [ptht_pkg::ID_W-1:0]          owner_r   [SLOTS];
  logic [ptht_pkg::PERIOD_W-1:0]      period_r  [SLOTS];
  logic [ptht_pkg::PERIOD_W-1:0]      elapsed_r [SLOTS];
  logic [ptht_pkg::COUNT_W-1:0]       ms_r, ms_nxt;

  logic [SLOTS-1:0]                   match, rel_oh, free_after, take_oh, fire;
  logic [ptht_pkg::PERIOD_W-1:0]      inc [SLOTS];
  logic                               found, free_any;
  logic [ptht_pkg::INDEX_W-1:0]       rel_idx, take_idx;
  logic [MW+SLOTS-1:0]                fire_ext;

  logic [ptht_pkg::MASK_W-1:0]        mask_nxt;
  logic [ptht_pkg::INDEX_W-1:0]       idx_nxt;
  logic                               ok_nxt;

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      match[s] = busy_r[s] && (owner_r[s] == in_hook_id);
      inc[s]   = elapsed_r[s] + 1'b1;
      fire[s]  = busy_r[s] && (inc[s] >= period_r[s]);
    end
  end

  // lowest set bit picks the slot
  assign rel_oh     = match & (~match + SLOTS'(1));
  assign free_after = ~(busy_r & ~rel_oh);
  assign take_oh    = free_after & (~free_after + SLOTS'(1));
  assign found      = |match;
  assign free_any   = |free_after;

  always_comb begin
    rel_idx  = '0;
    take_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (rel_oh[s])  rel_idx  = rel_idx  | ptht_pkg::INDEX_W'(s);
      if (take_oh[s]) take_idx = take_idx | ptht_pkg::INDEX_W'(s);
    end
  end

  // slots from eight upwards have no mask bit
  assign fire_ext = {{MW{1'b0}}, fire};

  always_comb begin
    busy_nxt = busy_r;
    ms_nxt   = ms_r;
    mask_nxt = '0;
    idx_nxt  = '0;
    ok_nxt   = 1'b0;
    if (ctrl.tick) begin
      ms_nxt   = ms_r + 1'b1;
      mask_nxt = fire_ext[MW-1:0];
    end
    if (ctrl.hook) begin
      busy_nxt = (busy_r & ~rel_oh) | take_oh;
      if (free_any) begin
        idx_nxt = take_idx;
        ok_nxt  = 1'b1;
      end
    end
    if (ctrl.unhook) begin
      busy_nxt = busy_r & ~rel_oh;
      if (found) begin
        idx_nxt = rel_idx;
        ok_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      ms_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      ms_r   <= ms_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SLOTS; s++) begin
      if (ctrl.tick && busy_r[s]) begin
        elapsed_r[s] <= fire[s] ? '0 : inc[s];
      end else if (ctrl.hook && take_oh[s]) begin
        owner_r[s]   <= in_hook_id;
        period_r[s]  <= in_period;
        elapsed_r[s] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_fire_mask  <= mask_nxt;
      out_slot_index <= idx_nxt;
      out_accepted   <= ok_nxt;
      out_ms_count   <= ms_nxt;
    end
  end

  assign stat.table_full  = &busy_r;
  assign stat.table_empty = ~|busy_r;

endmodule

// File: verif/periodic_tick_hook_table_unit_tb.sv
// self-checking testbench for the periodic tick hook table unit
module periodic_tick_hook_table_unit_tb;

  localparam int NSLOTS = 8;
  localparam logic [ptht_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_BLOCKS = 9;
  localparam int BLOCK_ITEMS = 150;

  typedef struct packed {
    logic [ptht_pkg::MASK_W-1:0]  fire_mask;
    logic [ptht_pkg::INDEX_W-1:0] slot_index;
    logic                         accepted;
    logic [ptht_pkg::COUNT_W-1:0] ms_count;
  } tick_result_t;

  // typed expectation attached to a transaction, used where it is obvious
  typedef struct packed {
    logic         fixed;
    tick_result_t want;
  } row_check_t;

  typedef struct packed {
    logic [ptht_pkg::CMD_W-1:0]    cmd;
    logic [ptht_pkg::ID_W-1:0]     id;
    logic [ptht_pkg::PERIOD_W-1:0] per;
    row_check_t                    chk;
  } stim_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [ptht_pkg::CMD_W-1:0]    in_command;
  logic [ptht_pkg::ID_W-1:0]     in_hook_id;
  logic [ptht_pkg::PERIOD_W-1:0] in_period;
  logic                          out_valid;
  logic                          out_stall;
  logic [ptht_pkg::MASK_W-1:0]   out_fire_mask;
  logic [ptht_pkg::INDEX_W-1:0]  out_slot_index;
  logic                          out_accepted;
  logic [ptht_pkg::COUNT_W-1:0]  out_ms_count;

  // predictor state
  logic                          occupied [NSLOTS];
  logic [ptht_pkg::ID_W-1:0]     owner_id [NSLOTS];
  logic [ptht_pkg::PERIOD_W-1:0] div_period [NSLOTS];
  logic [ptht_pkg::PERIOD_W-1:0] div_count [NSLOTS];
  logic [ptht_pkg::COUNT_W-1:0]  tick_count;

  tick_result_t expected_results [$];
  row_check_t   row_checks [$];
  stim_row_t    directed_rows [$];
  int           errors = 0;
  int           quiet_cycles;
  bit           calm;

  periodic_tick_hook_table_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_hook_id     (in_hook_id),
    .in_period      (in_period),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fire_mask  (out_fire_mask),
    .out_slot_index (out_slot_index),
    .out_accepted   (out_accepted),
    .out_ms_count   (out_ms_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // frees the lowest busy slot owned by id, -1 when there is none
  function automatic int release_owner(input logic [ptht_pkg::ID_W-1:0] id);
    for (int s = 0; s < NSLOTS; s++) begin
      if (occupied[s] && owner_id[s] == id) begin
        occupied[s] = 1'b0;
        return s;
      end
    end
    return -1;
  endfunction

  function automatic tick_result_t apply_command(input logic [ptht_pkg::CMD_W-1:0] cmd,
                                                 input logic [ptht_pkg::ID_W-1:0] id,
                                                 input logic [ptht_pkg::PERIOD_W-1:0] per);
    tick_result_t r;
    int hit;
    r = '0;
    case (cmd)
      ptht_pkg::CMD_TICK: begin
        tick_count = tick_count + 1'b1;
        for (int s = 0; s < NSLOTS; s++) begin
          if (occupied[s]) begin
            div_count[s] = div_count[s] + 1'b1;
            if (div_count[s] >= div_period[s]) begin
              div_count[s] = '0;
              r.fire_mask[s] = 1'b1;
            end
          end
        end
      end
      ptht_pkg::CMD_HOOK: begin
        hit = release_owner(id);
        for (int s = 0; s < NSLOTS; s++) begin
          if (!occupied[s] && !r.accepted) begin
            occupied[s] = 1'b1;
            owner_id[s] = id;
            div_period[s] = per;
            div_count[s] = '0;
            r.slot_index = s[ptht_pkg::INDEX_W-1:0];
            r.accepted = 1'b1;
          end
        end
      end
      ptht_pkg::CMD_UNHOOK: begin
        hit = release_owner(id);
        if (hit >= 0) begin
          r.slot_index = hit[ptht_pkg::INDEX_W-1:0];
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    r.ms_count = tick_count;
    return r;
  endfunction

  task automatic add_row(input logic [ptht_pkg::CMD_W-1:0] cmd,
                         input logic [ptht_pkg::ID_W-1:0] id,
                         input logic [ptht_pkg::PERIOD_W-1:0] per, input logic fixed,
                         input logic [ptht_pkg::MASK_W-1:0] mask,
                         input logic [ptht_pkg::INDEX_W-1:0] idx,
                         input logic acc, input logic [ptht_pkg::COUNT_W-1:0] ms);
    stim_row_t row;
    row.cmd = cmd;
    row.id = id;
    row.per = per;
    row.chk.fixed = fixed;
    row.chk.want = '{fire_mask: mask, slot_index: idx, accepted: acc, ms_count: ms};
    directed_rows.push_back(row);
  endtask

  task automatic send_item(input logic [ptht_pkg::CMD_W-1:0] cmd,
                           input logic [ptht_pkg::ID_W-1:0] id,
                           input logic [ptht_pkg::PERIOD_W-1:0] per, input row_check_t chk);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_checks.push_back(chk);
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_hook_id <= id;
    in_period  <= per;
    do @(posedge clk); while (in_stall);
  endtask

  // hold the sender off until every outstanding result has been taken
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // predicts on input transactions and checks output transactions
  always @(posedge clk) begin : monitor
    tick_result_t want;
    tick_result_t pred;
    row_check_t   chk;
    bit           moved;
    if (!rst_n) begin
      for (int s = 0; s < NSLOTS; s++) begin
        occupied[s] = 1'b0;
        owner_id[s] = '0;
        div_period[s] = '0;
        div_count[s] = '0;
      end
      tick_count = '0;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        chk = row_checks.size() != 0 ? row_checks.pop_front() : '0;
        pred = apply_command(in_command, in_hook_id, in_period);
        expected_results.push_back(chk.fixed ? chk.want : pred);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_fire_mask !== want.fire_mask)
            report_mismatch($sformatf("fire_mask %h, expected %h",
                                      out_fire_mask, want.fire_mask));
          if (out_slot_index !== want.slot_index)
            report_mismatch($sformatf("slot_index %0d, expected %0d",
                                      out_slot_index, want.slot_index));
          if (out_accepted !== want.accepted)
            report_mismatch($sformatf("accepted %b, expected %b",
                                      out_accepted, want.accepted));
          if (out_ms_count !== want.ms_count)
            report_mismatch($sformatf("ms_count %0d, expected %0d",
                                      out_ms_count, want.ms_count));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int n;
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int mode;
    int pick;
    logic [ptht_pkg::ID_W-1:0]     id_base;
    logic [ptht_pkg::CMD_W-1:0]    cmd;
    logic [ptht_pkg::ID_W-1:0]     id;
    logic [ptht_pkg::PERIOD_W-1:0] per;
    calm = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= ptht_pkg::CMD_TICK;
    in_hook_id <= '0;
    in_period  <= '0;

    //       command               id     period        fixed mask   idx   acc   ms
    add_row(ptht_pkg::CMD_TICK,   8'h00, 32'h0,        1'b1, 8'h00, 3'd0, 1'b0, 32'd1);
    add_row(ptht_pkg::CMD_UNHOOK, 8'h00, 32'h0,        1'b1, 8'h00, 3'd0, 1'b0, 32'd1);  // id absent
    add_row(CMD_UNUSED,           8'hFF, 32'hFFFFFFFF, 1'b1, 8'h00, 3'd0, 1'b0, 32'd1);
    add_row(ptht_pkg::CMD_HOOK,   8'h00, 32'h0,        1'b1, 8'h00, 3'd0, 1'b1, 32'd1);
    add_row(ptht_pkg::CMD_TICK,   8'h00, 32'h0,        1'b1, 8'h01, 3'd0, 1'b0, 32'd2);  // period 0 fires
    add_row(ptht_pkg::CMD_HOOK,   8'hFF, 32'hFFFFFFFF, 1'b1, 8'h00, 3'd1, 1'b1, 32'd2);
    add_row(ptht_pkg::CMD_HOOK,   8'h5A, 32'h2,        1'b1, 8'h00, 3'd2, 1'b1, 32'd2);
    add_row(ptht_pkg::CMD_TICK,   8'h00, 32'h0,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);
    add_row(ptht_pkg::CMD_TICK,   8'hA5, 32'h5555AAAA, 1'b0, 8'h00, 3'd0, 1'b0, 32'd0);
    add_row(ptht_pkg::CMD_HOOK,   8'h5A, 32'h1,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);  // re-hook, same slot
    add_row(ptht_pkg::CMD_UNHOOK, 8'h00, 32'h0,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);
    add_row(ptht_pkg::CMD_HOOK,   8'h5A, 32'h3,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);  // re-hook, lower slot
    add_row(ptht_pkg::CMD_HOOK,   8'h01, 32'h1,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);
    add_row(ptht_pkg::CMD_HOOK,   8'h02, 32'h2,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);
    add_row(ptht_pkg::CMD_HOOK,   8'h03, 32'h3,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);
    add_row(ptht_pkg::CMD_HOOK,   8'h04, 32'h4,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);
    add_row(ptht_pkg::CMD_HOOK,   8'h05, 32'h0,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);
    add_row(ptht_pkg::CMD_HOOK,   8'h06, 32'h7,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);
    add_row(ptht_pkg::CMD_HOOK,   8'h77, 32'h1,        1'b1, 8'h00, 3'd0, 1'b0, 32'd4);  // table full
    add_row(ptht_pkg::CMD_HOOK,   8'h06, 32'h1,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);  // present id while full
    add_row(ptht_pkg::CMD_TICK,   8'h00, 32'h0,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);
    add_row(ptht_pkg::CMD_UNHOOK, 8'hFF, 32'h0,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);
    add_row(ptht_pkg::CMD_UNHOOK, 8'hFF, 32'h0,        1'b1, 8'h00, 3'd0, 1'b0, 32'd5);  // now absent
    add_row(ptht_pkg::CMD_HOOK,   8'h03, 32'h0,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);
    add_row(ptht_pkg::CMD_TICK,   8'h00, 32'h0,        1'b0, 8'h00, 3'd0, 1'b0, 32'd0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].id, directed_rows[i].per,
                directed_rows[i].chk);
    wait_all_results();

    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      // modes: 0 fills the table, 1 drains it, 2 mixes
      mode = $urandom_range(0, 2);
      calm = (blk % 3 == 2);
      id_base = ptht_pkg::ID_W'($urandom_range(0, 255));
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5)
          cmd = CMD_UNUSED;
        else if (pick < 40)
          cmd = ptht_pkg::CMD_TICK;
        else if (mode == 0)
          cmd = (pick < 85) ? ptht_pkg::CMD_HOOK : ptht_pkg::CMD_UNHOOK;
        else if (mode == 1)
          cmd = (pick < 60) ? ptht_pkg::CMD_HOOK : ptht_pkg::CMD_UNHOOK;
        else
          cmd = (pick < 70) ? ptht_pkg::CMD_HOOK : ptht_pkg::CMD_UNHOOK;
        // a small id pool so that hooks and unhooks meet ids already present
        if ($urandom_range(0, 7) == 0)
          id = ptht_pkg::ID_W'($urandom_range(0, 255));
        else
          id = id_base + ptht_pkg::ID_W'($urandom_range(0, 9));
        pick = $urandom_range(0, 15);
        if (cmd != ptht_pkg::CMD_HOOK || pick == 13)
          per = $urandom;
        else if (pick < 10)
          per = $urandom_range(0, 5);
        else if (pick < 13)
          per = $urandom_range(6, 40);
        else if (pick == 14)
          per = '1;
        else
          per = '0;
        send_item(cmd, id, per, '0);
      end
      wait_all_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
